// ===== src/frame_fragment_reassembly_tracker_unit_assert.svh =====
// Assertion macros used by the tracker control module.
`ifndef FRAME_FRAGMENT_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH
`define FRAME_FRAGMENT_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH

// Same-cycle implication under an active-low reset.
`define FRTU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frtu assertion failed");

// Next-cycle implication under an active-low reset.
`define FRTU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frtu assertion failed");

`endif

// ===== src/frtu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package frtu_pkg;

    localparam int ID_W    = 32;
    localparam int TS_W    = 32;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int FLAG_W  = 8;
    localparam int LEN_W   = 11;
    localparam int BYTES_W = 17;
    localparam logic [BYTES_W-1:0] BYTE_SAT = 17'h1FFFF;

    localparam logic REG_KEYFRAME_FLAG_MASK      = 1'b0;
    localparam logic REG_KEYFRAME_REQUEST_ENABLE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_CLEAR,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_INVALID   = 2'd2,
        ST_STALE     = 2'd3
    } status_t;

    typedef struct packed {
        logic [LEN_W-1:0]  payload_length;
        logic [FLAG_W-1:0] flag_bits;
        logic [TS_W-1:0]   timestamp;
        logic [CNT_W-1:0]  fragment_total;
        logic [IDX_W-1:0]  fragment_index;
        logic [ID_W-1:0]   frame_id;
    } item_t;

    typedef struct packed {
        logic [BYTES_W-1:0] done_byte_total;
        logic               done_keyframe;
        logic [TS_W-1:0]    done_timestamp;
        logic [ID_W-1:0]    done_frame_id;
        logic               frame_done;
        logic               keyframe_request;
        status_t            status;
    } result_t;

    typedef struct packed {
        logic [FLAG_W-1:0] keyframe_flag_mask;
        logic              keyframe_request_enable;
    } cfg_t;

    typedef struct packed {
        logic    drop;
        status_t status;
    } verdict_t;

endpackage

`default_nettype wire

// ===== src/frtu_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

module frtu_check #(
    parameter int MAX_FRAGMENTS = 64,
    parameter int MAX_PAYLOAD   = 2047
) (
    input  wire frtu_pkg::item_t              item,
    input  wire logic [frtu_pkg::ID_W-1:0]    last_completed_id,
    output frtu_pkg::verdict_t                verdict
);

    logic bad_len;
    logic bad_total;
    logic bad_index;
    logic stale;

    assign bad_len   = (item.payload_length == '0) ||
                       ({5'd0, item.payload_length} > 16'(MAX_PAYLOAD));
    assign bad_total = (item.fragment_total == '0) ||
                       (item.fragment_total > frtu_pkg::CNT_W'(MAX_FRAGMENTS));
    assign bad_index = {1'b0, item.fragment_index} >= item.fragment_total;
    assign stale     = (last_completed_id != '0) && (item.frame_id < last_completed_id);

    always_comb
    begin
        verdict.drop   = 1'b0;
        verdict.status = frtu_pkg::ST_STORED;
        if (bad_len || bad_total || bad_index)
        begin
            verdict.drop   = 1'b1;
            verdict.status = frtu_pkg::ST_INVALID;
        end
        else if (stale)
        begin
            verdict.drop   = 1'b1;
            verdict.status = frtu_pkg::ST_STALE;
        end
    end

endmodule

`default_nettype wire

// ===== src/frtu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "frame_fragment_reassembly_tracker_unit_assert.svh"

module frtu_ctrl #(
    parameter int PENDING_LIMIT = 32,
    parameter int MAX_FRAGMENTS = 64
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               in_accept,
    input  wire frtu_pkg::item_t              in_item,
    input  wire frtu_pkg::verdict_t           in_verdict,
    input  wire frtu_pkg::cfg_t               cfg,
    output logic                              in_ready,
    output logic                              res_valid,
    input  wire                               res_take,
    output frtu_pkg::result_t                 res,
    output logic [frtu_pkg::ID_W-1:0]         last_completed_id
);

    localparam int SLOTS = PENDING_LIMIT + 1;
    localparam int SW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int MIW   = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;

    frtu_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    frtu_pkg::item_t  item_reg, item_next;
    frtu_pkg::result_t res_reg, res_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    logic [frtu_pkg::ID_W-1:0] last_id_reg, last_id_next;

    logic                       have_free_reg, have_free_next;
    logic [SW-1:0]              free_reg, free_next;
    logic                       have_old_reg, have_old_next;
    logic [SW-1:0]              old_reg, old_next;
    logic [frtu_pkg::ID_W-1:0]  old_id_reg, old_id_next;
    logic                       old_kf_reg, old_kf_next;
    logic                       have_match_reg, have_match_next;
    logic [SW-1:0]              match_reg, match_next;
    logic [frtu_pkg::TS_W-1:0]  m_ts_reg, m_ts_next;
    logic [frtu_pkg::CNT_W-1:0] m_exp_reg, m_exp_next;
    logic [frtu_pkg::CNT_W-1:0] m_rcv_reg, m_rcv_next;
    logic                       m_kf_reg, m_kf_next;
    logic [MAX_FRAGMENTS-1:0]   m_map_reg, m_map_next;
    logic [frtu_pkg::BYTES_W-1:0] m_bytes_reg, m_bytes_next;

    logic [frtu_pkg::ID_W-1:0]    mem_id    [SLOTS];
    logic [frtu_pkg::TS_W-1:0]    mem_ts    [SLOTS];
    logic [frtu_pkg::CNT_W-1:0]   mem_exp   [SLOTS];
    logic [frtu_pkg::CNT_W-1:0]   mem_rcv   [SLOTS];
    logic                         mem_kf    [SLOTS];
    logic [MAX_FRAGMENTS-1:0]     mem_map   [SLOTS];
    logic [frtu_pkg::BYTES_W-1:0] mem_bytes [SLOTS];

    logic [frtu_pkg::ID_W-1:0]    rd_id;
    logic [frtu_pkg::TS_W-1:0]    rd_ts;
    logic [frtu_pkg::CNT_W-1:0]   rd_exp;
    logic [frtu_pkg::CNT_W-1:0]   rd_rcv;
    logic                         rd_kf;
    logic [MAX_FRAGMENTS-1:0]     rd_map;
    logic [frtu_pkg::BYTES_W-1:0] rd_bytes;

    logic                         rd_en;
    logic [SW-1:0]                rd_addr;
    logic                         wr_en;
    logic [CW-1:0]                cnt_m1;
    logic [SW-1:0]                pidx;
    logic                         proc;
    logic                         last_beat;

    logic                         evict;
    logic                         hit;
    logic [SW-1:0]                slot;
    logic [frtu_pkg::TS_W-1:0]    b_ts;
    logic [frtu_pkg::CNT_W-1:0]   b_exp;
    logic [frtu_pkg::CNT_W-1:0]   b_rcv;
    logic                         b_kf;
    logic [MAX_FRAGMENTS-1:0]     b_map;
    logic [frtu_pkg::BYTES_W-1:0] b_bytes;
    logic [MIW-1:0]               idx_m;
    logic                         dup;
    logic [frtu_pkg::BYTES_W:0]   sum;
    logic [frtu_pkg::BYTES_W-1:0] n_bytes;
    logic [MAX_FRAGMENTS-1:0]     n_map;
    logic [frtu_pkg::CNT_W-1:0]   n_rcv;
    logic                         done;

    assign cnt_m1    = cnt_reg - CW'(1);
    assign pidx      = cnt_m1[SW-1:0];
    assign proc      = cnt_reg != '0;
    assign last_beat = cnt_reg == CW'(SLOTS);
    assign rd_addr   = cnt_reg[SW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_id[slot]    <= item_reg.frame_id;
            mem_ts[slot]    <= b_ts;
            mem_exp[slot]   <= b_exp;
            mem_rcv[slot]   <= n_rcv;
            mem_kf[slot]    <= b_kf;
            mem_map[slot]   <= n_map;
            mem_bytes[slot] <= n_bytes;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_id    <= mem_id[rd_addr];
            rd_ts    <= mem_ts[rd_addr];
            rd_exp   <= mem_exp[rd_addr];
            rd_rcv   <= mem_rcv[rd_addr];
            rd_kf    <= mem_kf[rd_addr];
            rd_map   <= mem_map[rd_addr];
            rd_bytes <= mem_bytes[rd_addr];
        end
    end

    // Merge the incoming fragment into the matched or newly opened slot.
    always_comb
    begin
        evict   = !have_free_reg;
        hit     = have_match_reg && !(evict && (match_reg == old_reg));
        slot    = hit ? match_reg : (evict ? old_reg : free_reg);
        b_ts    = hit ? m_ts_reg  : item_reg.timestamp;
        b_exp   = hit ? m_exp_reg : item_reg.fragment_total;
        b_rcv   = hit ? m_rcv_reg : '0;
        b_kf    = hit ? m_kf_reg
                      : |(item_reg.flag_bits & cfg.keyframe_flag_mask);
        b_map   = hit ? m_map_reg : '0;
        b_bytes = hit ? m_bytes_reg : '0;
        idx_m   = item_reg.fragment_index[MIW-1:0];
        dup     = b_map[idx_m];
        sum     = {1'b0, b_bytes} + (frtu_pkg::BYTES_W + 1)'(item_reg.payload_length);
        if (dup)
        begin
            n_bytes = b_bytes;
            n_map   = b_map;
            n_rcv   = b_rcv;
        end
        else
        begin
            n_bytes = (sum > {1'b0, frtu_pkg::BYTE_SAT}) ? frtu_pkg::BYTE_SAT
                                                          : sum[frtu_pkg::BYTES_W-1:0];
            n_map   = b_map | (MAX_FRAGMENTS'(1) << idx_m);
            n_rcv   = b_rcv + frtu_pkg::CNT_W'(1);
        end
        done = n_rcv == b_exp;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frtu_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = in_verdict.drop ? frtu_pkg::S_FINISH : frtu_pkg::S_SCAN;
                end
            end
            frtu_pkg::S_SCAN:
            begin
                if (last_beat)
                begin
                    state_next = frtu_pkg::S_UPDATE;
                end
            end
            frtu_pkg::S_UPDATE:
            begin
                state_next = done ? frtu_pkg::S_CLEAR : frtu_pkg::S_FINISH;
            end
            frtu_pkg::S_CLEAR:
            begin
                if (last_beat)
                begin
                    state_next = frtu_pkg::S_FINISH;
                end
            end
            frtu_pkg::S_FINISH:
            begin
                if (res_take)
                begin
                    state_next = frtu_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = frtu_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        unique case (state_reg)
            frtu_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
            end
            frtu_pkg::S_SCAN, frtu_pkg::S_CLEAR:
            begin
                rd_en = !last_beat;
            end
            frtu_pkg::S_UPDATE:
            begin
                wr_en = 1'b1;
            end
            frtu_pkg::S_FINISH:
            begin
                res_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        item_next       = item_reg;
        res_next        = res_reg;
        valid_next      = valid_reg;
        last_id_next    = last_id_reg;
        have_free_next  = have_free_reg;
        free_next       = free_reg;
        have_old_next   = have_old_reg;
        old_next        = old_reg;
        old_id_next     = old_id_reg;
        old_kf_next     = old_kf_reg;
        have_match_next = have_match_reg;
        match_next      = match_reg;
        m_ts_next       = m_ts_reg;
        m_exp_next      = m_exp_reg;
        m_rcv_next      = m_rcv_reg;
        m_kf_next       = m_kf_reg;
        m_map_next      = m_map_reg;
        m_bytes_next    = m_bytes_reg;
        unique case (state_reg)
            frtu_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    item_next       = in_item;
                    cnt_next        = '0;
                    have_free_next  = 1'b0;
                    have_old_next   = 1'b0;
                    have_match_next = 1'b0;
                    res_next        = '0;
                    res_next.status = in_verdict.status;
                end
            end
            frtu_pkg::S_SCAN:
            begin
                cnt_next = last_beat ? '0 : cnt_reg + CW'(1);
                if (proc)
                begin
                    if (valid_reg[pidx])
                    begin
                        if (!have_old_reg || (rd_id < old_id_reg))
                        begin
                            have_old_next = 1'b1;
                            old_next      = pidx;
                            old_id_next   = rd_id;
                            old_kf_next   = rd_kf;
                        end
                        if (rd_id == item_reg.frame_id)
                        begin
                            have_match_next = 1'b1;
                            match_next      = pidx;
                            m_ts_next       = rd_ts;
                            m_exp_next      = rd_exp;
                            m_rcv_next      = rd_rcv;
                            m_kf_next       = rd_kf;
                            m_map_next      = rd_map;
                            m_bytes_next    = rd_bytes;
                        end
                    end
                    else if (!have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_next      = pidx;
                    end
                end
            end
            frtu_pkg::S_UPDATE:
            begin
                if (evict)
                begin
                    valid_next[old_reg] = 1'b0;
                end
                valid_next[slot]          = 1'b1;
                res_next.status           = dup ? frtu_pkg::ST_DUPLICATE : frtu_pkg::ST_STORED;
                res_next.keyframe_request = evict && old_kf_reg && cfg.keyframe_request_enable;
                res_next.frame_done       = done;
                if (done)
                begin
                    res_next.done_frame_id   = item_reg.frame_id;
                    res_next.done_timestamp  = b_ts;
                    res_next.done_keyframe   = b_kf;
                    res_next.done_byte_total = n_bytes;
                    last_id_next             = item_reg.frame_id;
                end
            end
            frtu_pkg::S_CLEAR:
            begin
                cnt_next = last_beat ? '0 : cnt_reg + CW'(1);
                if (proc && valid_reg[pidx] && (rd_id <= item_reg.frame_id))
                begin
                    valid_next[pidx] = 1'b0;
                end
            end
            frtu_pkg::S_FINISH:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= frtu_pkg::S_IDLE;
            cnt_reg        <= '0;
            valid_reg      <= '0;
            last_id_reg    <= '0;
            have_free_reg  <= 1'b0;
            have_old_reg   <= 1'b0;
            have_match_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            valid_reg      <= valid_next;
            last_id_reg    <= last_id_next;
            have_free_reg  <= have_free_next;
            have_old_reg   <= have_old_next;
            have_match_reg <= have_match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        res_reg     <= res_next;
        free_reg    <= free_next;
        old_reg     <= old_next;
        old_id_reg  <= old_id_next;
        old_kf_reg  <= old_kf_next;
        match_reg   <= match_next;
        m_ts_reg    <= m_ts_next;
        m_exp_reg   <= m_exp_next;
        m_rcv_reg   <= m_rcv_next;
        m_kf_reg    <= m_kf_next;
        m_map_reg   <= m_map_next;
        m_bytes_reg <= m_bytes_next;
    end

    assign res               = res_reg;
    assign last_completed_id = last_id_reg;

    `FRTU_ASSERT_IMP(a_done_is_stored, clk, rst_n,
        (state_reg == frtu_pkg::S_FINISH) && res_reg.frame_done,
        res_reg.status == frtu_pkg::ST_STORED)
    `FRTU_ASSERT_IMP(a_drop_is_quiet, clk, rst_n,
        (state_reg == frtu_pkg::S_FINISH) && ((res_reg.status == frtu_pkg::ST_INVALID) ||
        (res_reg.status == frtu_pkg::ST_STALE)),
        !res_reg.frame_done && !res_reg.keyframe_request)
    `FRTU_ASSERT_NXT(a_scan_flow, clk, rst_n,
        state_reg == frtu_pkg::S_SCAN,
        (state_reg == frtu_pkg::S_SCAN) || (state_reg == frtu_pkg::S_UPDATE))

endmodule

`default_nettype wire

// ===== src/frame_fragment_reassembly_tracker_unit.sv =====
// Fragment reassembly tracker. One fragment descriptor enters per s_axis beat
// and exactly one result leaves per m_axis beat, in the same order.
// Configuration is written through cfg_we, cfg_index and cfg_wdata while idle;
// the user must keep to this, as the block does not enforce it. Index 0 is the
// keyframe flag mask, index 1 the keyframe request enable. s_axis_tready is high
// only while no fragment is in work. An invalid or stale fragment goes straight
// to the finish state, skipping the slot memory. Any other fragment scans all
// PENDING_LIMIT+1 entries of the slot memory, one entry a cycle through its
// single read port, then writes the merged entry back. A fragment completing a
// frame sweeps the slot memory once more to retire its own and older frames.
// Results sit in an output register; when the receiver stalls, the next
// fragment is still accepted and worked on, and its result waits until the
// register drains. Reset empties all slots, zeroes the last completed id and
// sets both configuration registers to one.
`timescale 1ns / 1ps
`default_nettype none

module frame_fragment_reassembly_tracker_unit #(
    parameter int PENDING_LIMIT = 32,
    parameter int MAX_FRAGMENTS = 64,
    parameter int MAX_PAYLOAD   = 2047
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // frame_id, fragment_index, fragment_total, timestamp, flag_bits, payload_length
    input  wire  [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status, keyframe_request, frame_done, done_frame_id, done_timestamp,
    // done_keyframe, done_byte_total, zero fill
    output logic [87:0] m_axis_tdata,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [7:0]  cfg_wdata
);

    frtu_pkg::cfg_t     cfg_reg, cfg_next;
    frtu_pkg::item_t    item;
    frtu_pkg::verdict_t verdict;
    frtu_pkg::result_t  res;
    frtu_pkg::result_t  out_reg, out_next;
    logic               out_valid_reg, out_valid_next;
    logic               in_accept;
    logic               res_valid;
    logic               res_take;
    logic [frtu_pkg::ID_W-1:0] last_completed_id;

    assign item      = s_axis_tdata;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign res_take  = res_valid && (!out_valid_reg || m_axis_tready);

    frtu_check #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .MAX_PAYLOAD   (MAX_PAYLOAD)
    ) u_check (
        .item              (item),
        .last_completed_id (last_completed_id),
        .verdict           (verdict)
    );

    frtu_ctrl #(
        .PENDING_LIMIT (PENDING_LIMIT),
        .MAX_FRAGMENTS (MAX_FRAGMENTS)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_accept         (in_accept),
        .in_item           (item),
        .in_verdict        (verdict),
        .cfg               (cfg_reg),
        .in_ready          (s_axis_tready),
        .res_valid         (res_valid),
        .res_take          (res_take),
        .res               (res),
        .last_completed_id (last_completed_id)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                frtu_pkg::REG_KEYFRAME_FLAG_MASK:
                begin
                    cfg_next.keyframe_flag_mask = cfg_wdata;
                end
                frtu_pkg::REG_KEYFRAME_REQUEST_ENABLE:
                begin
                    cfg_next.keyframe_request_enable = cfg_wdata[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.keyframe_flag_mask      <= 8'd1;
            cfg_reg.keyframe_request_enable <= 1'b1;
            out_valid_reg                   <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg};

endmodule

`default_nettype wire

// ===== tb/frtu_checker.sv =====
`timescale 1ns / 1ps

module frtu_checker
    import frtu_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [95:0] s_axis_tdata,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [87:0] m_axis_tdata,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [7:0]  cfg_wdata,
    output int          fail_count,
    output int          outstanding
);

    localparam int SLOTS = 33;
    localparam int PENDING_MAX = 32;
    localparam int FRAG_MAX = 64;

    result_t            expected_results[$];
    logic [FLAG_W-1:0]  key_mask;
    logic               key_req_en;
    logic [ID_W-1:0]    last_done_id;
    logic               pend_valid[SLOTS];
    logic [ID_W-1:0]    pend_id[SLOTS];
    logic [TS_W-1:0]    pend_ts[SLOTS];
    logic [CNT_W-1:0]   pend_need[SLOTS];
    logic [CNT_W-1:0]   pend_got[SLOTS];
    logic               pend_key[SLOTS];
    logic [63:0]        pend_map[SLOTS];
    logic [BYTES_W-1:0] pend_bytes[SLOTS];

    assign outstanding = expected_results.size();

    task automatic track_fragment(input item_t f);
        result_t          r;
        int               cnt;
        int               oldest;
        int               hit;
        int               free_i;
        logic [BYTES_W:0] sum;
        r = '0;
        r.status = ST_STORED;
        if (f.payload_length == 0 || f.fragment_total == 0 || f.fragment_total > FRAG_MAX
            || f.fragment_index >= f.fragment_total) begin
            r.status = ST_INVALID;
        end
        else if (last_done_id != 0 && f.frame_id < last_done_id) begin
            r.status = ST_STALE;
        end
        else begin
            cnt = 0;
            oldest = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (pend_valid[i]) begin
                    cnt++;
                    if (oldest < 0 || pend_id[i] < pend_id[oldest])
                        oldest = i;
                end
            end
            if (cnt > PENDING_MAX && oldest >= 0) begin
                if (pend_key[oldest] && key_req_en)
                    r.keyframe_request = 1'b1;
                pend_valid[oldest] = 1'b0;
            end
            hit = -1;
            free_i = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (pend_valid[i]) begin
                    if (pend_id[i] == f.frame_id)
                        hit = i;
                end
                else if (free_i < 0) begin
                    free_i = i;
                end
            end
            if (hit < 0) begin
                hit = (free_i < 0) ? 0 : free_i;
                pend_valid[hit] = 1'b1;
                pend_id[hit] = f.frame_id;
                pend_ts[hit] = f.timestamp;
                pend_need[hit] = f.fragment_total;
                pend_got[hit] = '0;
                pend_key[hit] = (f.flag_bits & key_mask) != 0;
                pend_map[hit] = '0;
                pend_bytes[hit] = '0;
            end
            if (pend_map[hit][f.fragment_index]) begin
                r.status = ST_DUPLICATE;
            end
            else begin
                sum = pend_bytes[hit] + f.payload_length;
                pend_map[hit][f.fragment_index] = 1'b1;
                pend_got[hit] = pend_got[hit] + 1'b1;
                pend_bytes[hit] = (sum > BYTE_SAT) ? BYTE_SAT : sum[BYTES_W-1:0];
            end
            if (pend_got[hit] == pend_need[hit]) begin
                r.frame_done = 1'b1;
                r.done_frame_id = pend_id[hit];
                r.done_timestamp = pend_ts[hit];
                r.done_keyframe = pend_key[hit];
                r.done_byte_total = pend_bytes[hit];
                last_done_id = pend_id[hit];
                for (int i = 0; i < SLOTS; i++) begin
                    if (pend_valid[i] && pend_id[i] <= r.done_frame_id)
                        pend_valid[i] = 1'b0;
                end
            end
        end
        expected_results.push_back(r);
    endtask

    task automatic field_check(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            expected_results.delete();
            key_mask = 8'd1;
            key_req_en = 1'b1;
            last_done_id = '0;
            for (int i = 0; i < SLOTS; i++)
                pend_valid[i] = 1'b0;
            fail_count = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == REG_KEYFRAME_FLAG_MASK)
                    key_mask = cfg_wdata;
                else if (cfg_index == REG_KEYFRAME_REQUEST_ENABLE)
                    key_req_en = cfg_wdata[0];
            end
            if (s_axis_tvalid && s_axis_tready)
                track_fragment(item_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation waiting: %h", m_axis_tdata);
                    fail_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    field_check("status", want.status, got.status);
                    field_check("keyframe_request", want.keyframe_request,
                                got.keyframe_request);
                    field_check("frame_done", want.frame_done, got.frame_done);
                    field_check("done_frame_id", want.done_frame_id, got.done_frame_id);
                    field_check("done_timestamp", want.done_timestamp, got.done_timestamp);
                    field_check("done_keyframe", want.done_keyframe, got.done_keyframe);
                    field_check("done_byte_total", want.done_byte_total,
                                got.done_byte_total);
                end
            end
        end
    end

endmodule

// ===== tb/tb_frame_fragment_reassembly_tracker_unit.sv =====
`timescale 1ns / 1ps

module tb_frame_fragment_reassembly_tracker_unit;
    import frtu_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE = 100;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_wdata;
    int          fail_count;
    int          outstanding;
    int          tx_idle;
    int          rx_idle;
    int          hold_req;
    int          hold_seen;
    int          hold_left;
    int          cycles;
    int          frags_sent;
    logic [31:0] next_id;

    frame_fragment_reassembly_tracker_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    frtu_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // The receiver owns the long hold-off so it is counted independently of the sender.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    function automatic item_t make_frag(input logic [31:0] fid, input int idx, input int total,
                                        input logic [31:0] ts, input logic [7:0] fl,
                                        input int len);
        item_t f;
        f.frame_id = fid;
        f.fragment_index = idx;
        f.fragment_total = total;
        f.timestamp = ts;
        f.flag_bits = fl;
        f.payload_length = len;
        return f;
    endfunction

    task automatic send_beat(input item_t f);
        while ($urandom_range(99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= f;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        frags_sent++;
    endtask

    task automatic drain_and_settle();
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_noise();
        item_t f;
        f = item_t'({$urandom, $urandom, $urandom});
        case ($urandom_range(3))
            0: f.payload_length = '0;
            1: f.fragment_total = '0;
            2: f.fragment_total = 7'd65 + $urandom_range(62);
            default:
            begin
                f.fragment_total = $urandom_range(1, 64);
                f.fragment_index = $urandom_range(f.fragment_total, 63);
                if (f.fragment_total == 64)
                    f.fragment_total = 0;
            end
        endcase
        send_beat(f);
    endtask

    function automatic int pick_len();
        case ($urandom_range(9))
            0: return 1;
            1: return 2047;
            default: return $urandom_range(1, 2047);
        endcase
    endfunction

    task automatic send_frame(input logic [31:0] fid, input int total, input bit whole,
                              input int dup_pct);
        int          order[64];
        int          n;
        int          j;
        int          t;
        logic [31:0] ts;
        logic [7:0]  fl;
        ts = $urandom;
        fl = $urandom;
        for (int k = 0; k < total; k++)
            order[k] = k;
        for (int k = total - 1; k > 0; k--)
        begin
            j = $urandom_range(k);
            t = order[k];
            order[k] = order[j];
            order[j] = t;
        end
        n = whole ? total : $urandom_range(1, (total > 1) ? total - 1 : 1);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(99) < 10)
                send_noise();
            if (k > 0 && $urandom_range(99) < dup_pct)
                send_beat(make_frag(fid, order[$urandom_range(k - 1)], total, $urandom,
                                    $urandom, pick_len()));
            if ($urandom_range(99) < 20)
                send_beat(make_frag(fid, order[k], total, $urandom, $urandom, pick_len()));
            else
                send_beat(make_frag(fid, order[k], total, ts, fl, pick_len()));
        end
    endtask

    task automatic flood_pending();
        logic [31:0] first;
        first = next_id;
        for (int k = 0; k < 36; k++)
        begin
            send_frame(next_id, $urandom_range(2, 4), 1'b0, 0);
            next_id = next_id + 1;
        end
        send_beat(make_frag(first, 0, 3, $urandom, 8'hFF, pick_len()));
        send_beat(make_frag(first + 4, 1, 2, $urandom, $urandom, pick_len()));
    endtask

    task automatic random_traffic(input int beats);
        int target;
        int total;
        target = frags_sent + beats;
        while (frags_sent < target)
        begin
            case ($urandom_range(19))
                0: flood_pending();
                1: send_beat(make_frag($urandom_range(next_id - 1), $urandom_range(1), 2,
                                       $urandom, $urandom, pick_len()));
                default:
                begin
                    total = ($urandom_range(19) == 0) ? $urandom_range(5, 64)
                                                      : $urandom_range(1, 4);
                    send_frame(next_id, total, $urandom_range(99) < 80, 15);
                    next_id = next_id + $urandom_range(1, 3);
                end
            endcase
        end
    endtask

    initial
    begin
        logic [7:0] masks[6];
        logic       enables[6];
        masks = '{8'd1, 8'd0, 8'hFF, 8'h5A, 8'hA5, 8'hFF};
        enables = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_we = 1'b0;
        cfg_index = REG_KEYFRAME_FLAG_MASK;
        cfg_wdata = '0;
        tx_idle = 0;
        rx_idle = 0;
        hold_req = 0;
        cycles = 0;
        frags_sent = 0;
        next_id = 32'd1000;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(make_frag(32'd7, 0, 1, 32'd1, 8'h01, 0));
        send_beat(make_frag(32'd7, 0, 0, 32'd1, 8'h01, 5));
        send_beat(make_frag(32'd7, 0, 65, 32'd1, 8'h01, 5));
        send_beat(make_frag(32'd7, 0, 127, 32'd1, 8'h01, 5));
        send_beat(make_frag(32'd7, 5, 5, 32'd1, 8'h01, 5));
        send_beat(make_frag(32'd0, 0, 1, 32'hFFFFFFFF, 8'hFF, 2047));
        send_beat(make_frag(32'd10, 0, 2, 32'd100, 8'h01, 1));
        send_beat(make_frag(32'd10, 0, 2, 32'd200, 8'h00, 9));
        send_beat(make_frag(32'd10, 1, 2, 32'd300, 8'h00, 2047));
        send_beat(make_frag(32'd5, 0, 1, 32'd0, 8'h00, 3));
        send_beat(make_frag(32'd10, 0, 1, 32'd400, 8'h00, 4));
        send_beat(make_frag(32'hFFFFFFFF, 1, 2, 32'd0, 8'hFF, 2047));
        send_beat(make_frag(32'd20, 63, 64, 32'h12345678, 8'h80, 2047));
        send_beat(make_frag(32'd20, 0, 64, 32'h0, 8'h00, 2047));
        send_beat(make_frag(32'd21, 63, 64, 32'h0, 8'h00, 1));
        send_beat(make_frag(32'd22, 0, 1, 32'h0, 8'h00, 1));

        for (int p = 0; p < 6; p++)
        begin
            drain_and_settle();
            write_reg(REG_KEYFRAME_FLAG_MASK, masks[p]);
            write_reg(REG_KEYFRAME_REQUEST_ENABLE, {7'd0, enables[p]});
            case (p / 2)
                0: begin tx_idle = 27; rx_idle = 73; end
                1: begin tx_idle = 73; rx_idle = 27; end
                default: begin tx_idle = 0; rx_idle = 0; end
            endcase
            if (p == 1)
            begin
                s_axis_tvalid <= 1'b0;
                hold_req <= hold_req + 1;
                @(posedge clk);
                flood_pending();
            end
            random_traffic(35);
            s_axis_tvalid <= 1'b0;
            while (outstanding != 0)
                @(posedge clk);
            random_traffic(35);
        end
        drain_and_settle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/frtu_pkg.sv
src/frtu_check.sv
src/frtu_ctrl.sv
src/frame_fragment_reassembly_tracker_unit.sv
tb/frtu_checker.sv
tb/tb_frame_fragment_reassembly_tracker_unit.sv
